// ----- src/cu_pkg.sv -----
package cu_pkg;

	localparam int RANK_W  = 42;
	localparam int SET_W   = 6;
	localparam int PICK_W  = 5;
	localparam int ELEM_W  = 6;
	localparam int POS_W   = 4;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_CFG   = 2'd2
	} status_t;

	// one queued job: rank plus the config snapshot it runs with
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [SET_W-1:0]  n;
		logic [PICK_W-1:0] k;
		logic              cfg_err;
	} job_t;

	// exact C(a,b) by Pascal rows; elaboration-time only
	function automatic logic [63:0] binom(input int a, input int b);
		logic [63:0] row [0:63];
		for (int j = 0; j < 64; j++) begin
			row[j] = (j == 0) ? 64'd1 : 64'd0;
		end
		for (int aa = 1; aa <= a; aa++) begin
			for (int j = 63; j > 0; j--) begin
				row[j] = row[j] + row[j-1];
			end
		end
		return (b >= 0 && b < 64) ? row[b] : 64'd0;
	endfunction

endpackage

// ----- src/combination_unrank_top.sv -----
// Lexicographic k-of-n combination unranking. A rank is taken on a clock edge
// with start high and busy low; the block then emits the k elements of that
// combination in ascending order, one beat per element on result_valid, each
// with its position and last set on the final one. Results cannot be held
// off: the receiver must take every beat in the cycle it appears. If the
// config is out of range (n = 0, n > N_MAX, k = 0, k > K_MAX or k > n) one
// beat with status 2 is given; if the rank is not below C(n,k), one beat
// with status 1. The back end tests one candidate value per cycle against a
// single registered read of the binomial table. A two-beat job queue sits
// between intake and the walker, so busy rises only when two ranks wait
// behind the one in progress. set_size and pick_size (index 0 and 1) are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. They
// reset to 8 and 4.
module combination_unrank_top #(
	parameter int N_MAX = 48,
	parameter int K_MAX = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config write port
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [cu_pkg::SET_W-1:0]    cfg_data,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  logic [cu_pkg::RANK_W-1:0]   rank_value,
	// result side
	output logic                        result_valid,
	output logic [cu_pkg::ELEM_W-1:0]   element,
	output logic [cu_pkg::POS_W-1:0]    position,
	output logic                        last,
	output logic [1:0]                  status
);

	localparam logic [1:0] CFG_SET_SIZE  = 2'd0;
	localparam logic [1:0] CFG_PICK_SIZE = 2'd1;

	logic [cu_pkg::SET_W-1:0]  set_size_q;
	logic [cu_pkg::PICK_W-1:0] pick_size_q;

	logic         push;
	logic         pop;
	logic         q_empty;
	logic         q_full;
	cu_pkg::job_t job_in;
	cu_pkg::job_t job_head;

	// config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q  <= cu_pkg::SET_W'(8);
			pick_size_q <= cu_pkg::PICK_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_SIZE:  set_size_q  <= cfg_data;
				CFG_PICK_SIZE: pick_size_q <= cfg_data[cu_pkg::PICK_W-1:0];
				default:       ;
			endcase
		end
	end

	assign busy = q_full;

	// intake: snapshot config, flag bad settings
	cu_front #(
		.N_MAX (N_MAX),
		.K_MAX (K_MAX)
	) u_front (
		.start      (start),
		.full       (q_full),
		.rank_value (rank_value),
		.set_size   (set_size_q),
		.pick_size  (pick_size_q),
		.push       (push),
		.job        (job_in)
	);

	cu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.dout   (job_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// walker: range check, then one candidate per cycle
	cu_back #(
		.N_MAX (N_MAX),
		.K_MAX (K_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (job_head),
		.q_empty      (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.element      (element),
		.position     (position),
		.last         (last),
		.status       (status)
	);

endmodule

// ----- src/cu_front.sv -----
module cu_front #(
	parameter int N_MAX = 48,
	parameter int K_MAX = 16
) (
	input  logic                        start,
	input  logic                        full,
	input  logic [cu_pkg::RANK_W-1:0]   rank_value,
	input  logic [cu_pkg::SET_W-1:0]    set_size,
	input  logic [cu_pkg::PICK_W-1:0]   pick_size,
	output logic                        push,
	output cu_pkg::job_t                job
);

	logic n_ok;
	logic k_ok;

	// config sanity: 1..N_MAX, 1..K_MAX, k <= n
	assign n_ok = (set_size != '0) && (set_size <= cu_pkg::SET_W'(N_MAX));
	assign k_ok = (pick_size != '0) && (pick_size <= cu_pkg::PICK_W'(K_MAX)) &&
	              ({1'b0, pick_size} <= set_size);

	assign push        = start && !full;
	assign job.rank    = rank_value;
	assign job.n       = set_size;
	assign job.k       = pick_size;
	assign job.cfg_err = !(n_ok && k_ok);

endmodule

// ----- src/cu_queue.sv -----
module cu_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cu_pkg::job_t din,
	input  logic         pop,
	output cu_pkg::job_t dout,
	output logic         empty,
	output logic         full
);

	// two-entry queue
	cu_pkg::job_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/cu_back.sv -----
module cu_back #(
	parameter int N_MAX = 48,
	parameter int K_MAX = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cu_pkg::job_t                head,
	input  logic                        q_empty,
	output logic                        pop,
	output logic                        result_valid,
	output logic [cu_pkg::ELEM_W-1:0]   element,
	output logic [cu_pkg::POS_W-1:0]    position,
	output logic                        last,
	output logic [1:0]                  status
);

	localparam int AW  = $clog2(N_MAX + 1);
	localparam int BW  = $clog2(K_MAX + 1);
	localparam int CW  = N_MAX;
	localparam int RW  = cu_pkg::RANK_W;
	localparam int MW  = (CW > RW) ? CW : RW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK
	} state_t;

	state_t                    state_q;
	logic [RW-1:0]             r_q;
	logic [cu_pkg::SET_W-1:0]  n_q;
	logic [cu_pkg::PICK_W-1:0] k_q;
	logic [AW-1:0]             a_q;
	logic [BW-1:0]             b_q;
	logic [cu_pkg::ELEM_W-1:0] v_q;
	logic [cu_pkg::POS_W-1:0]  i_q;
	logic [CW-1:0]             cnt_q;

	logic [CW-1:0] rom [N_MAX+1][K_MAX+1];
	logic [AW-1:0] rd_a;
	logic [BW-1:0] rd_b;
	logic          hit;
	logic          fnd;
	logic          done;

	// Pascal table, constant contents
	for (genvar ga = 0; ga <= N_MAX; ga++) begin : g_row
		for (genvar gb = 0; gb <= K_MAX; gb++) begin : g_col
			assign rom[ga][gb] = CW'(cu_pkg::binom(ga, gb));
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= rom[rd_a][rd_b];
	end

	assign hit  = MW'(r_q) < MW'(cnt_q);
	// last candidate of a position is taken regardless
	assign fnd  = hit || (AW'(b_q) == a_q);
	assign done = fnd && (b_q == '0);
	assign pop  = (state_q == ST_IDLE) && !q_empty;

	// next read address follows this cycle's decision
	always_comb begin
		rd_a = '0;
		rd_b = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty && !head.cfg_err) begin
					rd_a = AW'(head.n);
					rd_b = BW'(head.k);
				end
			end
			ST_CHECK: begin
				if (hit) begin
					rd_a = AW'(n_q - 1'b1);
					rd_b = BW'(k_q - 1'b1);
				end
			end
			ST_WALK: begin
				if (!done) begin
					rd_a = a_q - 1'b1;
					rd_b = fnd ? b_q - 1'b1 : b_q;
				end
			end
			default: begin
				rd_a = '0;
				rd_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
			element      <= '0;
			position     <= '0;
			last         <= 1'b0;
			status       <= cu_pkg::STATUS_OK;
			r_q          <= '0;
			n_q          <= '0;
			k_q          <= '0;
			a_q          <= '0;
			b_q          <= '0;
			v_q          <= '0;
			i_q          <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						r_q <= head.rank;
						n_q <= head.n;
						k_q <= head.k;
						if (head.cfg_err) begin
							result_valid <= 1'b1;
							element      <= '0;
							position     <= '0;
							last         <= 1'b1;
							status       <= cu_pkg::STATUS_CFG;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (!hit) begin
						result_valid <= 1'b1;
						element      <= '0;
						position     <= '0;
						last         <= 1'b1;
						status       <= cu_pkg::STATUS_RANGE;
						state_q      <= ST_IDLE;
					end else begin
						a_q     <= AW'(n_q - 1'b1);
						b_q     <= BW'(k_q - 1'b1);
						v_q     <= '0;
						i_q     <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!hit) begin
						r_q <= r_q - RW'(cnt_q);
					end
					a_q <= a_q - 1'b1;
					v_q <= v_q + 1'b1;
					if (fnd) begin
						result_valid <= 1'b1;
						element      <= v_q;
						position     <= i_q;
						last         <= (b_q == '0);
						status       <= cu_pkg::STATUS_OK;
						b_q          <= b_q - 1'b1;
						i_q          <= i_q + 1'b1;
					end
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sim/combination_unrank_top_tb.sv -----
`timescale 1ns / 100ps

module combination_unrank_top_tb;

	localparam int RANK_W = cu_pkg::RANK_W;
	localparam int SET_W  = cu_pkg::SET_W;
	localparam int PICK_W = cu_pkg::PICK_W;
	localparam int ELEM_W = cu_pkg::ELEM_W;
	localparam int POS_W  = cu_pkg::POS_W;

	localparam int N_MAX = 48;
	localparam int K_MAX = 16;
	// cycles with neither an accepted rank nor a result beat before giving up
	localparam int STALL_LIMIT = 2000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 40;

	// config register indexes
	localparam logic [1:0] REG_SET_SIZE  = 2'd0;
	localparam logic [1:0] REG_PICK_SIZE = 2'd1;
	localparam logic [1:0] REG_SPARE_A   = 2'd2;
	localparam logic [1:0] REG_SPARE_B   = 2'd3;

	localparam logic [RANK_W-1:0] RANK_ALL_ONES = {RANK_W{1'b1}};

	// one expected result beat
	typedef struct packed {
		logic [ELEM_W-1:0] element;
		logic [POS_W-1:0]  position;
		logic              last;
		cu_pkg::status_t   status;
	} beat_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [SET_W-1:0]   cfg_data;
	logic               start;
	logic               busy;
	logic [RANK_W-1:0]  rank_value;
	logic               result_valid;
	logic [ELEM_W-1:0]  element;
	logic [POS_W-1:0]   position;
	logic               last;
	logic [1:0]         status;

	combination_unrank_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.rank_value   (rank_value),
		.result_valid (result_valid),
		.element      (element),
		.position     (position),
		.last         (last),
		.status       (status)
	);

	// exact binomials, Pascal rows built at time zero
	logic [63:0] pascal [0:N_MAX][0:K_MAX];

	// shadow of the two config registers
	logic [SET_W-1:0]  cur_set;
	logic [PICK_W-1:0] cur_pick;

	beat_t expected_beats [$];

	int  ranks_sent;
	int  beats_seen;
	int  error_beats;
	int  mismatches;
	int  configs_used;
	int  stall_count;
	bit  gaps_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] choose(input int a, input int b);
		if (a < 0 || b < 0 || a > N_MAX || b > K_MAX)
			return 64'd0;
		return pascal[a][b];
	endfunction

	function automatic void push_beat(input int elem, input int pos, input bit fin,
			input cu_pkg::status_t st);
		beat_t b;
		b.element  = ELEM_W'(elem);
		b.position = POS_W'(pos);
		b.last     = fin;
		b.status   = st;
		expected_beats.push_back(b);
	endfunction

	// expected beats for one accepted rank under the current config
	function automatic void predict_combination(input logic [RANK_W-1:0] r);
		int n;
		int k;
		int prev;
		int found;
		int v;
		int i;
		bit hit;
		logic [63:0] rem;
		logic [63:0] cnt;
		n = int'(cur_set);
		k = int'(cur_pick);
		if (n < 1 || n > N_MAX || k < 1 || k > K_MAX || k > n) begin
			push_beat(0, 0, 1'b1, cu_pkg::STATUS_CFG);
		end else if ({22'd0, r} >= choose(n, k)) begin
			push_beat(0, 0, 1'b1, cu_pkg::STATUS_RANGE);
		end else begin
			rem = {22'd0, r};
			prev = -1;
			for (i = 0; i < k; i++) begin
				found = n - (k - i);
				hit = 1'b0;
				// walk candidates, peeling off the count of combos starting at v
				for (v = prev + 1; v <= n - (k - i) && !hit; v++) begin
					cnt = choose(n - 1 - v, k - 1 - i);
					if (rem < cnt) begin
						found = v;
						hit = 1'b1;
					end else begin
						rem = rem - cnt;
					end
				end
				prev = found;
				push_beat(found, i, i == k - 1, cu_pkg::STATUS_OK);
			end
		end
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES)
			$display("mismatch @%0t: %s", $realtime, msg);
	endfunction

	// result checker: every beat against the oldest expectation
	always @(posedge clk) begin : check_beats
		beat_t exp_b;
		if (arst_n && result_valid) begin
			beats_seen++;
			if (status != cu_pkg::STATUS_OK)
				error_beats++;
			if (expected_beats.size() == 0) begin
				note_mismatch($sformatf("unexpected beat elem=%0d pos=%0d last=%0b st=%0d",
					element, position, last, status));
			end else begin
				exp_b = expected_beats.pop_front();
				if (element !== exp_b.element || position !== exp_b.position ||
						last !== exp_b.last || status !== exp_b.status)
					note_mismatch($sformatf(
						"exp elem=%0d pos=%0d last=%0b st=%0d, got elem=%0d pos=%0d last=%0b st=%0d",
						exp_b.element, exp_b.position, exp_b.last, exp_b.status,
						element, position, last, status));
			end
		end
	end

	// watchdog: progress is an accepted rank or a result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles, %0d beats still owed",
					STALL_LIMIT, expected_beats.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// one rank beat; returns after the edge that accepted it, start left high
	task automatic send_rank(input logic [RANK_W-1:0] r);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 6) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		rank_value <= r;
		do
			@(posedge clk);
		while (busy);
		predict_combination(r);
		ranks_sent++;
	endtask

	// stop sending and wait until every owed beat has shown up
	task automatic wait_for_all_beats();
		@(negedge clk);
		start <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// block idle: nothing owed plus a margin for the walker to wind down
	task automatic settle_idle();
		wait_for_all_beats();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [SET_W-1:0] data);
		settle_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SET_SIZE:  cur_set = data;
			REG_PICK_SIZE: cur_pick = data[PICK_W-1:0];
			default: ;	// spare indexes do nothing
		endcase
	endtask

	task automatic set_config(input logic [SET_W-1:0] n, input logic [SET_W-1:0] k);
		write_reg(REG_SET_SIZE, n);
		write_reg(REG_PICK_SIZE, k);
		configs_used++;
	endtask

	function automatic logic [RANK_W-1:0] random_rank();
		logic [63:0] lim;
		logic [63:0] raw;
		int sel;
		lim = choose(int'(cur_set), int'(cur_pick));
		raw = {$urandom, $urandom};
		sel = $urandom_range(99);
		if (sel < 72 && lim != 0)
			return RANK_W'(raw % lim);
		else if (sel < 80)
			return RANK_W'(lim - 64'd1);	// last valid rank
		else if (sel < 87)
			return RANK_W'(lim);			// first out of range
		else if (sel < 93)
			return '0;
		return raw[RANK_W-1:0];
	endfunction

	// reset values of n = 8, k = 4 without any write
	task automatic test_reset_defaults();
		send_rank('0);
		send_rank(RANK_W'(69));		// last combination {4,5,6,7}
		send_rank(RANK_W'(70));		// C(8,4): out of range
		send_rank(RANK_ALL_ONES);
		settle_idle();
	endtask

	task automatic test_extreme_sizes();
		logic [63:0] c;
		set_config(6'd48, 6'd16);
		c = choose(48, 16);
		send_rank('0);
		send_rank(RANK_W'(c - 64'd1));
		send_rank(RANK_W'(c));
		send_rank(RANK_ALL_ONES);
		set_config(6'd1, 6'd1);
		send_rank('0);
		send_rank(RANK_W'(1));
		// k equal to n: a single combination
		set_config(6'd16, 6'd16);
		send_rank('0);
		send_rank(RANK_W'(1));
		set_config(6'd48, 6'd1);
		send_rank(RANK_W'(47));
		send_rank(RANK_W'(48));
		settle_idle();
	endtask

	// config errors, masking of the pick field, writes to spare indexes
	task automatic test_bad_config();
		set_config(6'd3, 6'd5);			// k above n
		send_rank('0);
		write_reg(REG_SET_SIZE, 6'd0);	// n of zero
		send_rank('0);
		set_config(6'h3F, 6'd1);		// n far above N_MAX
		send_rank(RANK_ALL_ONES);
		set_config(6'd49, 6'd1);		// n just above N_MAX
		send_rank(RANK_W'(5));
		set_config(6'd20, 6'd0);		// k of zero
		send_rank('0);
		set_config(6'd20, 6'd17);		// k just above K_MAX
		send_rank(RANK_W'(1));
		write_reg(REG_PICK_SIZE, 6'h3F);	// top bit dropped, k = 31
		send_rank('0);
		write_reg(REG_PICK_SIZE, 6'h21);	// top bit dropped, k = 1
		send_rank(RANK_W'(19));
		send_rank(RANK_W'(20));
		set_config(6'd10, 6'd3);
		write_reg(REG_SPARE_A, 6'h3F);
		write_reg(REG_SPARE_B, 6'h00);
		send_rank(RANK_W'(119));		// still n = 10, k = 3
		send_rank(RANK_W'(120));
		settle_idle();
	endtask

	task automatic test_random_traffic();
		int p;
		int j;
		int n;
		int k;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				set_config(6'd48, 6'd16);
			end else if (p == 1) begin
				set_config(6'd2, 6'd1);
			end else if ($urandom_range(99) < 80) begin
				n = $urandom_range(1, N_MAX);
				k = $urandom_range(1, (n < K_MAX) ? n : K_MAX);
				set_config(SET_W'(n), SET_W'(k));
			end else begin
				set_config(SET_W'($urandom), SET_W'($urandom));
			end
			// one phase runs back to back with no sender gaps
			gaps_on = (p != 2);
			for (j = 0; j < ITEMS_PER_PHASE; j++) begin
				if ((p == 3 && j == ITEMS_PER_PHASE / 2) || $urandom_range(99) < 3)
					wait_for_all_beats();
				send_rank(random_rank());
			end
			settle_idle();
		end
		gaps_on = 1'b1;
	endtask

	initial begin : main
		int a;
		int b;
		arst_n     = 1'b0;
		start      = 1'b0;
		rank_value = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_SET_SIZE;
		cfg_data   = '0;
		cur_set    = SET_W'(8);
		cur_pick   = PICK_W'(4);
		gaps_on    = 1'b1;
		ranks_sent = 0;
		beats_seen = 0;
		error_beats = 0;
		mismatches = 0;
		configs_used = 1;
		stall_count = 0;
		for (a = 0; a <= N_MAX; a++) begin
			for (b = 0; b <= K_MAX; b++) begin
				if (b == 0)
					pascal[a][b] = 64'd1;
				else if (a == 0)
					pascal[a][b] = 64'd0;
				else
					pascal[a][b] = pascal[a-1][b-1] + pascal[a-1][b];
			end
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_extreme_sizes();
		test_bad_config();
		test_random_traffic();
		settle_idle();

		$display("summary: %0d ranks over %0d config settings, %0d beats checked",
			ranks_sent, configs_used, beats_seen);
		$display("summary: %0d error-status beats, %0d mismatches, %0d beats still owed",
			error_beats, mismatches, expected_beats.size());
		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/cu_pkg.sv
src/cu_front.sv
src/cu_queue.sv
src/cu_back.sv
src/combination_unrank_top.sv
sim/combination_unrank_top_tb.sv
